[src/bpl_pkg.sv]
package bpl_pkg;

	localparam int unsigned COORD_W = 32;
	localparam int unsigned CHILD_W = 16;
	localparam int unsigned LEAF_W = 15;
	localparam int unsigned NUM_W = 15;
	localparam int unsigned COUNT_W = 13;
	localparam int unsigned INDEX_W = 12;
	localparam int unsigned FRAC_W = 16;
	localparam int unsigned PROD_W = COORD_W + FRAC_W;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_LOCATE = 1'b1;

	localparam int unsigned LEAF_BIT = CHILD_W - 1;

	typedef struct packed {
		logic command;
		logic [INDEX_W-1:0] node_index;
		logic signed [COORD_W-1:0] line_x;
		logic signed [COORD_W-1:0] line_y;
		logic signed [COORD_W-1:0] line_dx;
		logic signed [COORD_W-1:0] line_dy;
		logic [CHILD_W-1:0] front_child;
		logic [CHILD_W-1:0] back_child;
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
	} in_item_t;

	typedef struct packed {
		logic [LEAF_W-1:0] leaf_index;
		logic walk_error;
	} out_item_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] origin_x;
		logic signed [COORD_W-1:0] origin_y;
		logic signed [COORD_W-1:0] dir_x;
		logic signed [COORD_W-1:0] dir_y;
		logic [CHILD_W-1:0] front_child;
		logic [CHILD_W-1:0] back_child;
	} node_t;

endpackage

[src/bpl_node_mem.sv]
module bpl_node_mem #(
	parameter int unsigned DEPTH = 4096,
	parameter int unsigned AW = 12
) (
	input logic clk,
	input logic wr_en,
	input logic [AW-1:0] wr_addr,
	input bpl_pkg::node_t wr_data,
	input logic rd_en,
	input logic [AW-1:0] rd_addr,
	output bpl_pkg::node_t rd_data
);

	bpl_pkg::node_t mem [DEPTH];
	bpl_pkg::node_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[src/bpl_side_test.sv]
module bpl_side_test (
	input logic clk,
	input bpl_pkg::node_t node,
	input logic signed [bpl_pkg::COORD_W-1:0] point_x,
	input logic signed [bpl_pkg::COORD_W-1:0] point_y,
	output logic side
);

	localparam int unsigned CW = bpl_pkg::COORD_W;
	localparam int unsigned FW = bpl_pkg::FRAC_W;
	localparam int unsigned PW = bpl_pkg::PROD_W;

	logic signed [CW-1:0] rx;
	logic signed [CW-1:0] ry;
	logic signed [FW-1:0] dx_int;
	logic signed [FW-1:0] dy_int;
	logic direct;
	logic direct_side;

	logic direct_s1;
	logic direct_side_s1;
	logic signed [PW-1:0] lhs_s1;
	logic signed [PW-1:0] rhs_s1;
	logic signed [CW-1:0] lhs_hi;
	logic signed [CW-1:0] rhs_hi;

	always_comb begin
		rx = point_x - node.origin_x;
		ry = point_y - node.origin_y;
		dx_int = node.dir_x[CW-1:CW-FW];
		dy_int = node.dir_y[CW-1:CW-FW];
		direct = 1'b1;
		direct_side = 1'b0;
		if (node.dir_x == '0) begin
			direct_side = (point_x <= node.origin_x) ? (node.dir_y > 0) : (node.dir_y < 0);
		end else if (node.dir_y == '0) begin
			direct_side = (point_y <= node.origin_y) ? (node.dir_x < 0) : (node.dir_x > 0);
		end else if (node.dir_y[CW-1] ^ node.dir_x[CW-1] ^ rx[CW-1] ^ ry[CW-1]) begin
			direct_side = node.dir_y[CW-1] ^ rx[CW-1];
		end else begin
			direct = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		direct_s1 <= direct;
		direct_side_s1 <= direct_side;
		lhs_s1 <= ry * dx_int;
		rhs_s1 <= dy_int * rx;
	end

	assign lhs_hi = lhs_s1[PW-1:FW];
	assign rhs_hi = rhs_s1[PW-1:FW];
	assign side = direct_s1 ? direct_side_s1 : !(lhs_hi < rhs_hi);

endmodule

[src/bsp_point_locate_top.sv]
// Point location in a binary space partition tree of up to MAX_NODES nodes held in one
// synchronous node memory. A load item (command 0) writes one node in the cycle it is
// accepted and gives no result; a locate item (command 1) walks from node node_count-1 to a
// leaf and gives one result. For each visited node the walk steps through a bounds check
// and memory read, the side test products, and the compare and child select. A walk that
// visits node_count nodes without reaching a leaf, or that meets a node number of MAX_NODES
// or more, returns leaf 0 with walk_error set. One item is in flight at a time; in_stall is
// high from the acceptance of a locate item until its result enters the output register.
// The result register lets a load be taken while the previous result is still stalled.
// The user must write node_count through cfg_wen/cfg_wdata only while the block is idle;
// the block itself does not enforce it. Nodes must be loaded before a walk reaches them.
module bsp_point_locate_top #(
	parameter int unsigned MAX_NODES = 4096
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input bpl_pkg::in_item_t in_item,
	output logic out_valid,
	input logic out_stall,
	output bpl_pkg::out_item_t out_item,
	input logic cfg_wen,
	input logic [bpl_pkg::COUNT_W-1:0] cfg_wdata
);

	localparam int unsigned AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int unsigned NW = bpl_pkg::NUM_W;
	localparam int unsigned KW = bpl_pkg::COUNT_W;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_CHECK = 3'd1;
	localparam logic [2:0] ST_READ = 3'd2;
	localparam logic [2:0] ST_TEST = 3'd3;
	localparam logic [2:0] ST_RESULT = 3'd4;

	logic [2:0] state_q;
	logic [KW-1:0] node_count_q;
	logic [NW-1:0] num_q;
	logic [KW-1:0] steps_q;
	logic signed [bpl_pkg::COORD_W-1:0] point_x_q;
	logic signed [bpl_pkg::COORD_W-1:0] point_y_q;
	bpl_pkg::out_item_t res_q;
	bpl_pkg::out_item_t out_item_q;
	logic out_valid_q;

	logic in_take;
	logic out_free;
	logic [NW-1:0] load_idx;
	logic mem_we;
	logic mem_re;
	bpl_pkg::node_t wr_node;
	bpl_pkg::node_t rd_node;
	logic side;
	logic [bpl_pkg::CHILD_W-1:0] child;
	logic walk_abort;

	assign in_stall = (state_q != ST_IDLE);
	assign in_take = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign load_idx = NW'(in_item.node_index);
	assign mem_we = in_take && (in_item.command == bpl_pkg::CMD_LOAD)
		&& (32'(load_idx) < MAX_NODES);
	assign mem_re = (state_q == ST_CHECK);
	assign walk_abort = (32'(num_q) >= MAX_NODES) || (steps_q >= node_count_q);
	assign child = side ? rd_node.back_child : rd_node.front_child;

	always_comb begin
		wr_node.origin_x = in_item.line_x;
		wr_node.origin_y = in_item.line_y;
		wr_node.dir_x = in_item.line_dx;
		wr_node.dir_y = in_item.line_dy;
		wr_node.front_child = in_item.front_child;
		wr_node.back_child = in_item.back_child;
	end

	bpl_node_mem #(
		.DEPTH(MAX_NODES),
		.AW(AW)
	) u_mem (
		.clk(clk),
		.wr_en(mem_we),
		.wr_addr(load_idx[AW-1:0]),
		.wr_data(wr_node),
		.rd_en(mem_re),
		.rd_addr(num_q[AW-1:0]),
		.rd_data(rd_node)
	);

	bpl_side_test u_side (
		.clk(clk),
		.node(rd_node),
		.point_x(point_x_q),
		.point_y(point_y_q),
		.side(side)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= '0;
		end else if (cfg_wen) begin
			node_count_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			num_q <= '0;
			steps_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_take && (in_item.command == bpl_pkg::CMD_LOCATE)) begin
						if (node_count_q == '0) begin
							state_q <= ST_RESULT;
						end else begin
							num_q <= NW'(node_count_q - 1'b1);
							steps_q <= '0;
							state_q <= ST_CHECK;
						end
					end
				end
				ST_CHECK: begin
					if (walk_abort) begin
						state_q <= ST_RESULT;
					end else begin
						steps_q <= steps_q + 1'b1;
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_TEST;
				end
				ST_TEST: begin
					if (child[bpl_pkg::LEAF_BIT]) begin
						state_q <= ST_RESULT;
					end else begin
						num_q <= child[NW-1:0];
						state_q <= ST_CHECK;
					end
				end
				ST_RESULT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			point_x_q <= in_item.point_x;
			point_y_q <= in_item.point_y;
			res_q <= '0;
		end else if ((state_q == ST_CHECK) && walk_abort) begin
			res_q <= {{bpl_pkg::LEAF_W{1'b0}}, 1'b1};
		end else if ((state_q == ST_TEST) && child[bpl_pkg::LEAF_BIT]) begin
			res_q <= {child[bpl_pkg::LEAF_W-1:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_RESULT) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_RESULT) && out_free) begin
			out_item_q <= res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item = out_item_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_RESULT))
		else $error("result raised outside the result state");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TEST) |-> $past(state_q == ST_READ))
		else $error("side test used without a preceding node read");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_item.walk_error) |-> (out_item.leaf_index == '0))
		else $error("aborted walk returned a nonzero leaf");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |-> (steps_q <= node_count_q) && (steps_q != '0))
		else $error("walk step count out of range");

endmodule
